// ===== rtl/szd_pkg.sv =====
`timescale 1ns / 1ps

package szd_pkg;

  localparam int WINDOW     = 256;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int FILL_W     = 9;
  localparam int SMP_W      = 16;
  localparam int THR_W      = 16;
  localparam int SUM_W      = 24;
  localparam int SQ_W       = 40;
  localparam int D_W        = 48;
  localparam int DIV_W      = 32;
  localparam int ROOT_W     = 32;
  localparam int RAD_W      = 64;
  localparam int MEAN_W     = 24;
  localparam int SD_W       = 24;
  localparam int STEP_W     = 5;
  localparam logic [THR_W-1:0] THR_RESET = 16'd768;

  // datapath commands, decoded from the controller state
  typedef struct packed {
    logic accept;
    logic div_load_mean;
    logic div_load_sd;
    logic div_step;
    logic prod;
    logic diff;
    logic sqrt_step;
    logic cmp1;
    logic cmp2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/sliding_window_zscore_detector.sv =====
`timescale 1ns / 1ps
// Sliding-window z-score detector.
// Input beat: sample in in_tdata, operation in in_tuser (0 judge, 1 judge and
// insert into the 256-sample window). One result beat per input beat: mean and
// stddev of the window before the beat (Q16.8), fill count, and the anomaly flag
// in out_tuser (|sample - mean| / stddev > threshold).
// cfg_* writes the Q8.8 threshold (reset 3.0); always ready, write only when idle.
// One item at a time: a new input beat is taken only once the previous result
// has gone into the output register. The time is set by the shared
// one-bit-a-cycle divider (mean, then stddev) and the 32-step digit-by-digit
// square root.
// A finished result sits in an output register; a new beat is accepted while it
// waits. If the receiver stalls, the next result is held back until the output
// register frees, and in_tready stays low meanwhile.
// Reset (synchronous, active low): window empty, sums zero, no result pending.
// The sample ring itself is not cleared; its entries are only used once written.
module sliding_window_zscore_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [23:0] mean, [47:24] stddev, [56:48] fill, rest 0
  output logic        out_tuser,  // [0] anomaly
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // z_threshold
);
  import szd_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [MEAN_W-1:0] mean;
  logic [SD_W-1:0]   sd;
  logic [FILL_W-1:0] fill;

  assign cfg_ready = 1'b1;

  szd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  szd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_tuser),
    .in_sample   (in_tdata),
    .cfg_we      (cfg_valid),
    .cfg_thr     (cfg_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_anomaly (out_tuser),
    .out_mean    (mean),
    .out_sd      (sd),
    .out_fill    (fill)
  );

  assign out_tdata = {7'b0, fill, sd, mean};

  // an anomaly needs a nonzero stddev
  a_anom_sd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:24] != 24'd0)
    else $error("anomaly with zero stddev");

  // fill count never passes the window depth
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[56:48] <= 9'd256)
    else $error("fill count beyond window");

  // empty window reports nothing
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[56:48] == 9'd0 |-> out_tdata[47:0] == 48'd0 && !out_tuser)
    else $error("empty window with nonzero stats");

  // a result never appears the cycle after a beat is taken
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result too early");

endmodule

// ===== rtl/szd_ctrl.sv =====
`timescale 1ns / 1ps

module szd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  szd_pkg::stat_t stat,
  output szd_pkg::cmd_t  cmd
);
  import szd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MDIV, S_PROD, S_DIFF, S_SQRT, S_SDLD, S_SDIV, S_CMP1, S_CMP2, S_OUT
  } state_t;

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept        = in_tvalid;
        cmd.div_load_mean = in_tvalid;
        cnt_nxt           = '0;
        if (in_tvalid) state_nxt = S_MDIV;
      end
      S_MDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) state_nxt = S_SDLD;
      end
      S_SDLD: begin
        cmd.div_load_sd = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = S_SDIV;
      end
      S_SDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_CMP1;
      end
      S_CMP1: begin
        cmd.cmp1  = 1'b1;
        state_nxt = S_CMP2;
      end
      S_CMP2: begin
        cmd.cmp2  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = !stat.out_busy;
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/szd_dp.sv =====
`timescale 1ns / 1ps

module szd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  szd_pkg::cmd_t                 cmd,
  output szd_pkg::stat_t                stat,
  input  logic                          in_op,
  input  logic signed [szd_pkg::SMP_W-1:0] in_sample,
  input  logic                          cfg_we,
  input  logic [szd_pkg::THR_W-1:0]     cfg_thr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_anomaly,
  output logic [szd_pkg::MEAN_W-1:0]    out_mean,
  output logic [szd_pkg::SD_W-1:0]      out_sd,
  output logic [szd_pkg::FILL_W-1:0]    out_fill
);
  import szd_pkg::*;

  // window state
  logic signed [SMP_W-1:0] ring_mem [WINDOW];
  logic [IDX_W-1:0]        wslot_r;
  logic [FILL_W-1:0]       filled_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sq_r;
  logic [THR_W-1:0]        thr_r;

  // item
  logic                    op_r;
  logic signed [SMP_W-1:0] smp_r, old_r;

  // divider
  logic [DIV_W-1:0]  dnd_r;
  logic [FILL_W-1:0] drem_r, dden_r;
  logic              neg_r;

  // products, root
  logic [D_W-1:0]    pa_r, pb_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+3:0] srem_r;
  logic [ROOT_W-1:0] root_r;
  logic signed [MEAN_W-1:0] mean_r;
  logic [SD_W-1:0]   sd_r;
  logic [SD_W+1:0]   adev_r;
  logic [2*SMP_W-1:0] sqs_r, sqo_r;
  logic [SQ_W-1:0]   tp_r;

  // output register
  logic              out_valid_r, out_anom_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [SD_W-1:0]   out_sd_r;
  logic [FILL_W-1:0] out_fill_r;

  logic signed [DIV_W-1:0] num;
  logic [DIV_W-1:0]  absnum;
  logic [SUM_W-1:0]  sabs;
  logic [FILL_W:0]   rtry;
  logic [DIV_W-1:0]  qc, mval;
  logic [D_W-1:0]    pa_full;
  logic [D_W-1:0]    pb_full;
  logic [ROOT_W+3:0] st, strial;
  logic signed [SD_W+1:0] dev;
  logic              full, anom, upd;

  always_comb begin
    num    = {sum_r, 8'b0};
    absnum = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
    sabs   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    rtry   = {drem_r, dnd_r[DIV_W-1]};
    qc     = dnd_r + DIV_W'(drem_r != '0);
    mval   = neg_r ? DIV_W'(-qc) : dnd_r;
    pa_full = filled_r * sq_r;
    pb_full = sabs * sabs;
    st     = {srem_r[ROOT_W+1:0], rad_r[RAD_W-1:RAD_W-2]};
    strial = {2'b00, root_r, 2'b01};
    dev    = {{2{smp_r[SMP_W-1]}}, smp_r, 8'b0} - {{2{mean_r[MEAN_W-1]}}, mean_r};
    full   = (filled_r == FILL_W'(WINDOW));
    anom   = (sd_r != '0) && ({6'b0, adev_r, 8'b0} > tp_r);
    upd    = cmd.out_load && op_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_r <= ring_mem[wslot_r];
      op_r  <= in_op;
      smp_r <= in_sample;
    end
    if (upd) ring_mem[wslot_r] <= smp_r;
  end

  // shared restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load_mean) begin
      dnd_r  <= absnum;
      drem_r <= '0;
      dden_r <= filled_r;
      neg_r  <= sum_r[SUM_W-1];
    end else if (cmd.div_load_sd) begin
      dnd_r  <= root_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      if (rtry >= {1'b0, dden_r}) begin
        drem_r <= FILL_W'(rtry - {1'b0, dden_r});
        dnd_r  <= {dnd_r[DIV_W-2:0], 1'b1};
      end else begin
        drem_r <= rtry[FILL_W-1:0];
        dnd_r  <= {dnd_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      mean_r <= (filled_r == '0) ? '0 : mval[MEAN_W-1:0];
      pa_r   <= pa_full;
      pb_r   <= pb_full;
    end
    if (cmd.diff) begin
      rad_r  <= {pa_r - pb_r, 16'b0};
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (st >= strial) begin
        srem_r <= st - strial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= st;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.cmp1) begin
      if (filled_r == '0) sd_r <= '0;
      else if (dnd_r[DIV_W-1:SD_W] != '0) sd_r <= '1;
      else sd_r <= dnd_r[SD_W-1:0];
      adev_r <= dev[SD_W+1] ? (SD_W+2)'(-dev) : (SD_W+2)'(dev);
      sqs_r  <= 32'(smp_r * smp_r);
      sqo_r  <= 32'(old_r * old_r);
    end
    if (cmd.cmp2) tp_r <= thr_r * sd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r  <= '0;
      filled_r <= '0;
      sum_r    <= '0;
      sq_r     <= '0;
      thr_r    <= THR_RESET;
    end else begin
      if (cfg_we) thr_r <= cfg_thr;
      if (upd) begin
        sum_r <= sum_r + SUM_W'(smp_r) - (full ? SUM_W'(old_r) : SUM_W'(0));
        sq_r  <= sq_r + SQ_W'(sqs_r) - (full ? SQ_W'(sqo_r) : SQ_W'(0));
        wslot_r <= (wslot_r == IDX_W'(WINDOW - 1)) ? '0 : wslot_r + 1'b1;
        if (!full) filled_r <= filled_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_anom_r <= anom;
      out_mean_r <= mean_r;
      out_sd_r   <= sd_r;
      out_fill_r <= filled_r;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid   = out_valid_r;
  assign out_anomaly = out_anom_r;
  assign out_mean    = out_mean_r;
  assign out_sd      = out_sd_r;
  assign out_fill    = out_fill_r;

endmodule

// ===== verif/sliding_window_zscore_detector_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_zscore_detector_tb;
  import szd_pkg::*;

  localparam int LATENCY    = 120;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic        anomaly;
    logic [23:0] mean;
    logic [23:0] stddev;
    logic [8:0]  fill;
  } zresult_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] sample
  logic        in_tuser = 1'b0; // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [23:0] mean, [47:24] stddev, [56:48] fill
  logic        out_tuser;       // [0] anomaly
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;   // z_threshold

  sliding_window_zscore_detector dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: shadow of the window, sums and threshold
  logic signed [15:0] win_ring [WINDOW];
  int unsigned        win_slot;
  int unsigned        win_fill;
  longint             win_sum;
  longint unsigned    win_sqsum;
  logic [15:0]        thr;

  zresult_t    pending_results[$];
  int          error_count = 0;
  int          results_seen = 0;
  int          anomalies_seen = 0;
  int          idle_pct = 6;     // sender and receiver idle odds, percent
  int          quiet_cycles = 0;

  // floor(sqrt(d * 65536)), bit by bit over 72 bits
  function automatic longint unsigned isqrt_q8(longint unsigned d);
    longint unsigned rem, root, trial;
    logic [71:0] rad;
    rad = {d[55:0], 16'h0};
    rem = 0;
    root = 0;
    for (int i = 35; i >= 0; i--) begin
      rem = (rem << 2) | rad[2*i +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Judge one sample against the window, then optionally insert it
  function automatic zresult_t judge_sample(logic op, logic signed [15:0] s);
    zresult_t        r;
    longint          num, mean, dev, old, sl;
    longint unsigned sq, d, sd, adev;
    int unsigned     n;
    n = win_fill;
    sl = longint'(s);
    mean = 0;
    sd = 0;
    r.anomaly = 1'b0;
    if (n > 0) begin
      num = win_sum * 256;
      if (num >= 0) mean = num / n;
      else mean = -((-num + n - 1) / n);
      sq = (win_sum < 0) ? -win_sum : win_sum;
      d = n * win_sqsum - sq * sq;
      if (d != 0) begin
        sd = isqrt_q8(d) / n;
        if (sd > 64'hFFFFFF) sd = 64'hFFFFFF;
      end
      if (sd != 0) begin
        dev = sl * 256 - mean;
        adev = (dev < 0) ? -dev : dev;
        if (adev * 256 > longint'(thr) * sd) r.anomaly = 1'b1;
      end
    end
    r.mean = mean[23:0];
    r.stddev = sd[23:0];
    r.fill = (n > 511) ? 9'd511 : n[8:0];
    if (op) begin
      if (win_fill >= WINDOW) begin
        old = win_ring[win_slot];
        win_sum -= old;
        win_sqsum -= old * old;
      end
      win_ring[win_slot] = s;
      win_sum += sl;
      win_sqsum += sl * sl;
      win_slot = (win_slot + 1) % WINDOW;
      if (win_fill < WINDOW) win_fill++;
    end
    return r;
  endfunction

  // Drive one input beat; prediction made on acceptance.
  // tvalid stays up into the next call so beats can go back to back.
  task automatic send_sample(logic op, logic [15:0] s);
    while (($urandom_range(99) < idle_pct)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(judge_sample(op, s));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Threshold write while idle
  task automatic write_threshold(logic [15:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    thr = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random backpressure, check each beat against oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          error_count++;
        end else begin
          zresult_t e;
          e = pending_results.pop_front();
          results_seen++;
          if (out_tuser) anomalies_seen++;
          if (out_tuser !== e.anomaly) begin
            $error("anomaly exp %0d got %0d", e.anomaly, out_tuser);
            error_count++;
          end
          if (out_tdata[23:0] !== e.mean) begin
            $error("window_mean exp %h got %h", e.mean, out_tdata[23:0]);
            error_count++;
          end
          if (out_tdata[47:24] !== e.stddev) begin
            $error("window_stddev exp %h got %h", e.stddev, out_tdata[47:24]);
            error_count++;
          end
          if (out_tdata[56:48] !== e.fill) begin
            $error("fill_count exp %0d got %0d", e.fill, out_tdata[56:48]);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: cycles with no beat accepted on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Empty window, zero variance, then field extremes
  task automatic test_directed();
    send_sample(1'b0, 16'h1234);     // empty window
    send_sample(1'b1, 16'h0005);
    send_sample(1'b1, 16'h0005);
    send_sample(1'b0, 16'h7FFF);     // zero variance, no anomaly
    send_sample(1'b1, 16'h8000);
    send_sample(1'b1, 16'h7FFF);
    send_sample(1'b0, 16'h8000);
    send_sample(1'b0, 16'h0000);
    send_sample(1'b0, 16'hFFFF);
    send_sample(1'b1, 16'hFFFF);
    send_sample(1'b0, 16'h5555);
    send_sample(1'b0, 16'hAAAA);
  endtask

  // Fill past WINDOW so the oldest samples leave the sums
  task automatic test_wrap(int count);
    for (int i = 0; i < count; i++)
      send_sample(1'b1, ($urandom_range(15) == 0) ? 16'(32'($urandom))
                                                  : 16'($urandom_range(600)) - 16'd300);
  endtask

  // Random mix: mostly inserts, occasional outliers
  task automatic test_random(int count);
    logic [15:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: s = 16'(32'($urandom));
        default: s = 16'($urandom_range(2000)) - 16'd1000;
      endcase
      send_sample($urandom_range(3) != 0, s);
    end
  endtask

  initial begin
    win_slot = 0;
    win_fill = 0;
    win_sum = 0;
    win_sqsum = 0;
    thr = THR_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    write_threshold(16'h0000);
    test_random(30);
    write_threshold(16'hFFFF);
    test_random(20);
    write_threshold(16'h0100);
    idle_pct = 0;                    // long stretch with no idling
    test_wrap(280);
    idle_pct = 6;
    drain_results();                 // sender waits until all results are in
    write_threshold(16'h0200);
    test_random(30);
    write_threshold(THR_RESET);
    test_random(30);

    drain_results();
    $display("Covered %0d results (%0d anomalies), thresholds 0..FFFF, window wrap.",
             results_seen, anomalies_seen);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
